FILE: src/bffa_pkg.sv
package bffa_pkg;

   // Heap geometry: the usable heap is the smaller of the heap size and the bitmap capacity.
   localparam int HEAP_BYTES = 4096;
   localparam int MAP_BYTES  = 512;
   localparam int HEAP_SIZE  = (HEAP_BYTES < MAP_BYTES * 8) ? HEAP_BYTES : MAP_BYTES * 8;
   localparam int SCAN_BYTES = (HEAP_SIZE + 7) / 8;
   localparam int ADDR_W     = $clog2(SCAN_BYTES);
   localparam int PTR_W      = ADDR_W + 1;

   // Field widths of the request and response.
   localparam int OFF_W = 12;
   localparam int LEN_W = 13;
   localparam int ST_W  = 2;

   typedef enum logic [ST_W-1:0] {
      ST_OK      = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_BAD     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_SETUP,
      S_MARK,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic load;
      logic scan;
      logic setup;
      logic mark;
      logic set_nospace;
      logic respond;
   } ctrl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic clear_last;
      logic req_bad;
      logic req_free;
      logic scan_found;
      logic scan_last;
      logic mark_last;
   } dp_status_type;

endpackage

FILE: src/bffa_ctrl.sv
module bffa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  bffa_pkg::dp_status_type dp_status,
   output bffa_pkg::ctrl_cmd_type  cmd
);
   import bffa_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register; reset begins the bitmap clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (dp_status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               if (dp_status.req_bad)       state_in = S_DONE;
               else if (dp_status.req_free) state_in = S_SETUP;
               else                         state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (dp_status.scan_found)     state_in = S_SETUP;
            else if (dp_status.scan_last) state_in = S_DONE;
         end
         S_SETUP: begin
            state_in = S_MARK;
         end
         S_MARK: begin
            if (dp_status.mark_last) state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
         end
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         S_SCAN: begin
            cmd.scan        = 1'b1;
            cmd.set_nospace = dp_status.scan_last && !dp_status.scan_found;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
         end
         S_MARK: begin
            cmd.mark = 1'b1;
         end
         S_DONE: begin
            cmd.respond = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: src/bffa_datapath.sv
module bffa_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_type,
   input  logic [bffa_pkg::OFF_W-1:0]   req_byte_offset,
   input  logic [bffa_pkg::LEN_W-1:0]   req_run_length,
   input  bffa_pkg::ctrl_cmd_type       cmd,
   output bffa_pkg::dp_status_type      dp_status,
   output logic                         rsp_strobe,
   output logic [bffa_pkg::ST_W-1:0]    rsp_status,
   output logic [bffa_pkg::OFF_W-1:0]   rsp_run_start
);
   import bffa_pkg::*;

   // Reservation bitmap, one bit per heap byte.
   logic [7:0] map_mem [SCAN_BYTES];

   logic              type_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [OFF_W-1:0]  start_ff;
   logic [OFF_W-1:0]  end_ff;
   status_type        stat_ff;
   logic [LEN_W-1:0]  run_ff;
   logic [PTR_W-1:0]  ptr_ff;
   logic              rd_vld_ff;
   logic [ADDR_W-1:0] ev_addr_ff;
   logic [7:0]        rd_data_ff;
   logic              rsp_strobe_ff;
   status_type        rsp_status_ff;
   logic [OFF_W-1:0]  rsp_run_start_ff;

   logic [LEN_W-1:0]   run_in;
   logic [OFF_W-1:0]   end_in;
   logic [LEN_W-1:0]   start_in;
   logic [PTR_W-1:0]   ptr_in;
   logic               req_bad;
   logic [LEN_W:0]     free_end;
   logic [ADDR_W-1:0]  end_byte;
   logic               rd_en;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [7:0]         wr_data;
   logic [7:0]         run_mask;
   logic               found;
   logic [LEN_W-1:0]   end_pos;

   // Request checks: zero length, allocation longer than the heap, free past the end.
   assign free_end = {2'b00, req_byte_offset} + {1'b0, req_run_length};
   always_comb begin
      req_bad = 1'b0;
      if (req_run_length == '0) begin
         req_bad = 1'b1;
      end else if (!req_type) begin
         req_bad = req_run_length > LEN_W'(HEAP_SIZE);
      end else begin
         req_bad = free_end > (LEN_W + 1)'(HEAP_SIZE);
      end
   end

   assign end_byte = end_ff[OFF_W-1:3];

   // Scan one map byte: count free bits and stop at the first bit that completes the run.
   always_comb begin
      logic [LEN_W-1:0] run;
      logic [LEN_W-1:0] pos;
      logic             taken;
      run     = run_ff;
      found   = 1'b0;
      end_pos = '0;
      for (int b = 0; b < 8; b++) begin
         pos   = LEN_W'({ev_addr_ff, 3'(b)});
         taken = rd_data_ff[b] || (pos >= LEN_W'(HEAP_SIZE));
         if (!found) begin
            if (taken) begin
               run = '0;
            end else begin
               run = run + 1'b1;
            end
            if (run == len_ff) begin
               found   = 1'b1;
               end_pos = pos;
            end
         end
      end
      run_in = run;
   end

   // Bits of the current map byte that fall inside the run being marked.
   always_comb begin
      logic [OFF_W-1:0] pos;
      for (int b = 0; b < 8; b++) begin
         pos         = OFF_W'({ev_addr_ff, 3'(b)});
         run_mask[b] = (pos >= start_ff) && (pos <= end_ff);
      end
   end

   // Memory port control: reads lead writes by one byte during marking.
   assign rd_en = (cmd.scan && (ptr_ff < PTR_W'(SCAN_BYTES)))
                  || (cmd.mark && (ptr_ff <= {1'b0, end_byte}));
   assign wr_en   = cmd.clear || (cmd.mark && rd_vld_ff);
   assign wr_addr = cmd.clear ? ptr_ff[ADDR_W-1:0] : ev_addr_ff;
   always_comb begin
      if (cmd.clear) begin
         wr_data = '0;
      end else if (type_ff) begin
         wr_data = rd_data_ff & ~run_mask;
      end else begin
         wr_data = rd_data_ff | run_mask;
      end
   end

   // Start of the run, recovered from its last byte and its length.
   assign start_in = LEN_W'(end_ff) + LEN_W'(1) - len_ff;

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = '0;
      end else if (cmd.setup) begin
         ptr_in = PTR_W'(start_in[OFF_W-1:3]);
      end else if (cmd.clear || rd_en) begin
         ptr_in = ptr_ff + 1'b1;
      end
   end

   always_comb begin
      end_in = end_ff;
      if (cmd.load) begin
         end_in = OFF_W'(free_end - 1'b1);
      end else if (cmd.scan && rd_vld_ff && found) begin
         end_in = end_pos[OFF_W-1:0];
      end
   end

   // Bitmap memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= map_mem[ptr_ff[ADDR_W-1:0]];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         ptr_ff        <= ptr_in;
         rd_vld_ff     <= rd_en;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   // Request and working registers.
   always_ff @(posedge clock) begin
      end_ff <= end_in;
      if (rd_en) begin
         ev_addr_ff <= ptr_ff[ADDR_W-1:0];
      end
      if (cmd.load) begin
         type_ff <= req_type;
         len_ff  <= req_run_length;
         run_ff  <= '0;
         stat_ff <= req_bad ? ST_BAD : ST_OK;
      end else begin
         if (cmd.scan && rd_vld_ff && !found) begin
            run_ff <= run_in;
         end
         if (cmd.set_nospace) begin
            stat_ff <= ST_NOSPACE;
         end
      end
      if (cmd.setup) begin
         start_ff <= start_in[OFF_W-1:0];
      end
      if (cmd.respond) begin
         rsp_status_ff    <= stat_ff;
         rsp_run_start_ff <= ((stat_ff == ST_OK) && !type_ff) ? start_ff : '0;
      end
   end

   assign dp_status.clear_last = ptr_ff == PTR_W'(SCAN_BYTES - 1);
   assign dp_status.req_bad    = req_bad;
   assign dp_status.req_free   = req_type;
   assign dp_status.scan_found = rd_vld_ff && found;
   assign dp_status.scan_last  = rd_vld_ff && !found
                                 && (ev_addr_ff == ADDR_W'(SCAN_BYTES - 1));
   assign dp_status.mark_last  = rd_vld_ff && (ev_addr_ff == end_byte);

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_run_start = rsp_run_start_ff;

   // A read and a write in the same cycle never touch the same map byte.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != ptr_ff[ADDR_W-1:0]))
      else $error("bitmap read and write collide on one address");

   // Marking never writes beyond the last byte of the run.
   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.mark && rd_vld_ff) |-> (ev_addr_ff <= end_byte))
      else $error("marking writes past the end of the run");

   // While scanning, the free run counted so far is shorter than the request.
   a_run_below_len: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> (run_ff < len_ff))
      else $error("scan run counter reached the length without stopping");

endmodule

FILE: src/bitmap_first_fit_allocator_unit.sv
// First-fit byte allocator over a 4096-byte heap, kept as a 512-byte reservation bitmap in a
// memory with one read and one write port. After reset the unit clears the bitmap with busy
// high. A request is taken when start is high and busy is low; its one response appears later
// on rsp_strobe for a single cycle and cannot be held off, so the receiver must take it then.
// A bad request goes straight from idle to the response state. A free skips the scan and
// clears its run in the marking pass; an allocation first scans for a fitting run and then
// marks it. Both are paced by the bitmap memory, which is read one map byte per cycle, first
// by the scan and then by the read-modify-write marking pass.
module bitmap_first_fit_allocator_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_type,
   input  logic [bffa_pkg::OFF_W-1:0]  req_byte_offset,
   input  logic [bffa_pkg::LEN_W-1:0]  req_run_length,
   output logic                        rsp_strobe,
   output logic [bffa_pkg::ST_W-1:0]   rsp_status,
   output logic [bffa_pkg::OFF_W-1:0]  rsp_run_start
);
   import bffa_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // Sequencing of clear, scan, mark and response.
   bffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // Bitmap memory, run search and marking.
   bffa_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_type),
      .req_byte_offset (req_byte_offset),
      .req_run_length  (req_run_length),
      .cmd             (cmd),
      .dp_status       (dp_status),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_run_start   (rsp_run_start)
   );

   // Only a successful allocation reports a non-zero start.
   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_OK)) |-> (rsp_run_start == '0))
      else $error("failed request reports a non-zero run start");

   // Responses are never issued in consecutive cycles.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

endmodule

FILE: bench/bitmap_first_fit_allocator_unit_tb.sv
module bitmap_first_fit_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bffa_pkg::*;

   localparam int RANDOM_REQUESTS = 1145;
   localparam int CALM_TAIL       = 150;
   localparam int WATCHDOG_LIMIT  = 6000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int LEN_MAX         = (1 << LEN_W) - 1;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef struct packed {
      status_type         status;
      logic [OFF_W-1:0]   run_start;
   } alloc_result_type;

   typedef struct packed {
      req_kind_type       kind;
      logic [OFF_W-1:0]   offset;
      logic [LEN_W-1:0]   length;
      logic               typed;
      status_type         status;
      logic [OFF_W-1:0]   run_start;
   } directed_row_type;

   typedef struct {
      int base;
      int length;
   } heap_run_type;

   // Directed requests. Rows with typed set carry their response; the rest use the predictor.
   localparam directed_row_type DIRECTED_ROWS [25] = '{
      '{REQ_ALLOC, 12'd0,    13'd0,    1'b1, ST_BAD,     12'd0},
      '{REQ_FREE,  12'd5,    13'd0,    1'b1, ST_BAD,     12'd0},
      '{REQ_ALLOC, 12'd0,    13'd4097, 1'b1, ST_BAD,     12'd0},
      '{REQ_ALLOC, 12'd4095, 13'd8191, 1'b1, ST_BAD,     12'd0},
      '{REQ_FREE,  12'd4095, 13'd2,    1'b1, ST_BAD,     12'd0},
      '{REQ_FREE,  12'd4095, 13'd8191, 1'b1, ST_BAD,     12'd0},
      '{REQ_FREE,  12'd0,    13'd4096, 1'b1, ST_OK,      12'd0},
      '{REQ_ALLOC, 12'd0,    13'd1,    1'b1, ST_OK,      12'd0},
      '{REQ_ALLOC, 12'd0,    13'd4096, 1'b1, ST_NOSPACE, 12'd0},
      '{REQ_ALLOC, 12'd0,    13'd4095, 1'b1, ST_OK,      12'd1},
      '{REQ_ALLOC, 12'd0,    13'd1,    1'b1, ST_NOSPACE, 12'd0},
      '{REQ_FREE,  12'd4095, 13'd1,    1'b1, ST_OK,      12'd0},
      '{REQ_ALLOC, 12'd4095, 13'd1,    1'b1, ST_OK,      12'd4095},
      '{REQ_FREE,  12'd0,    13'd4096, 1'b1, ST_OK,      12'd0},
      '{REQ_ALLOC, 12'd0,    13'd4096, 1'b1, ST_OK,      12'd0},
      '{REQ_ALLOC, 12'd0,    13'd1,    1'b1, ST_NOSPACE, 12'd0},
      '{REQ_FREE,  12'd100,  13'd10,   1'b1, ST_OK,      12'd0},
      '{REQ_ALLOC, 12'd0,    13'd11,   1'b1, ST_NOSPACE, 12'd0},
      '{REQ_ALLOC, 12'd0,    13'd10,   1'b1, ST_OK,      12'd100},
      '{REQ_FREE,  12'd0,    13'd4096, 1'b1, ST_OK,      12'd0},
      '{REQ_FREE,  12'd0,    13'd4096, 1'b1, ST_OK,      12'd0},
      '{REQ_ALLOC, 12'd2730, 13'd3,    1'b1, ST_OK,      12'd0},
      '{REQ_FREE,  12'd1,    13'd1,    1'b1, ST_OK,      12'd0},
      '{REQ_ALLOC, 12'd1365, 13'd2,    1'b0, ST_OK,      12'd0},
      '{REQ_ALLOC, 12'd0,    13'd1,    1'b0, ST_OK,      12'd0}
   };

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               start           = 1'b0;
   logic               busy;
   logic               req_type        = 1'b0;
   logic [OFF_W-1:0]   req_byte_offset = '0;
   logic [LEN_W-1:0]   req_run_length  = '0;
   logic               rsp_strobe;
   logic [ST_W-1:0]    rsp_status;
   logic [OFF_W-1:0]   rsp_run_start;

   // Predicted reservation state, one flag per heap byte.
   bit                 heap_taken [HEAP_SIZE];
   alloc_result_type   expected_results [$];
   heap_run_type       live_runs [$];
   int                 error_count  = 0;
   int                 stall_cycles = 0;

   bitmap_first_fit_allocator_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_byte_offset (req_byte_offset),
      .req_run_length  (req_run_length),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_run_start   (rsp_run_start)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   // First-fit allocation and freeing over the predicted heap; returns the response.
   function automatic alloc_result_type predict_heap_request(input req_kind_type kind,
                                                              input int offset,
                                                              input int length);
      alloc_result_type result;
      int               free_run;
      result.status    = ST_OK;
      result.run_start = '0;
      free_run         = 0;
      if (length == 0) begin
         result.status = ST_BAD;
      end else if (kind == REQ_ALLOC) begin
         if (length > HEAP_SIZE) begin
            result.status = ST_BAD;
         end else begin
            result.status = ST_NOSPACE;
            for (int i = 0; i < HEAP_SIZE; i++) begin
               if (heap_taken[i]) free_run = 0;
               else free_run++;
               if (free_run == length) begin
                  result.status    = ST_OK;
                  result.run_start = OFF_W'(i + 1 - length);
                  for (int j = i + 1 - length; j <= i; j++) heap_taken[j] = 1'b1;
                  break;
               end
            end
         end
      end else if (offset + length > HEAP_SIZE) begin
         result.status = ST_BAD;
      end else begin
         for (int j = offset; j < offset + length; j++) heap_taken[j] = 1'b0;
      end
      return result;
   endfunction

   // Presents one request, waits for it to be taken and records its expected response.
   task automatic send_request(input req_kind_type kind, input logic [OFF_W-1:0] offset,
                               input logic [LEN_W-1:0] length, input logic typed,
                               input status_type typed_status,
                               input logic [OFF_W-1:0] typed_start);
      alloc_result_type predicted;
      heap_run_type     run;
      req_type        <= kind;
      req_byte_offset <= offset;
      req_run_length  <= length;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = predict_heap_request(kind, int'(offset), int'(length));
      // Keep track of reserved runs so that later frees can target them.
      if (predicted.status == ST_OK && kind == REQ_ALLOC) begin
         run.base   = int'(predicted.run_start);
         run.length = int'(length);
         live_runs.push_back(run);
      end
      if (predicted.status == ST_OK && kind == REQ_FREE && int'(length) == HEAP_SIZE) begin
         live_runs.delete();
      end
      if (typed) begin
         predicted.status    = typed_status;
         predicted.run_start = typed_start;
      end
      expected_results.push_back(predicted);
   endtask

   // Each response is compared with the oldest outstanding expectation.
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("response with status %0d and start %0d, none expected",
                                      rsp_status, rsp_run_start));
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            if (rsp_run_start !== want.run_start)
               report_mismatch($sformatf("run start %0d, expected %0d", rsp_run_start,
                                         want.run_start));
         end
      end
   end

   // The run is abandoned when neither a request nor a response moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      req_kind_type       kind;
      logic [OFF_W-1:0]   offset;
      logic [LEN_W-1:0]   length;
      heap_run_type       run;
      int                 pick;
      int                 idx;
      int                 sub;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table: bad requests, heap extremes and simple first-fit cases.
      foreach (DIRECTED_ROWS[r]) begin
         send_request(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].offset, DIRECTED_ROWS[r].length,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].status,
                      DIRECTED_ROWS[r].run_start);
      end

      // Random traffic: mostly allocations paired with frees of live runs, plus noise.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if ((n == 300 || n == 700) && expected_results.size() != 0) begin
            start <= 1'b0;
            while (expected_results.size() != 0) @(posedge clock);
         end else if (n < RANDOM_REQUESTS - CALM_TAIL && (n / 90) % 4 != 3 &&
                      $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end

         pick   = $urandom_range(0, 99);
         offset = OFF_W'($urandom_range(0, HEAP_SIZE - 1));
         if (live_runs.size() > 48 && pick < 45) pick = 60;
         if (live_runs.size() == 0 && pick >= 45 && pick < 78) pick = 0;
         kind = REQ_FREE;
         if (pick < 45) begin
            // Allocation, mostly short; the offset field is ignored but still varied.
            kind = REQ_ALLOC;
            sub  = $urandom_range(0, 99);
            if (sub < 80) length = LEN_W'($urandom_range(1, 32));
            else if (sub < 95) length = LEN_W'($urandom_range(1, 300));
            else if (sub < 99) length = LEN_W'($urandom_range(301, HEAP_SIZE));
            else length = LEN_W'($urandom_range(HEAP_SIZE + 1, LEN_MAX));
         end else if (pick < 78) begin
            // Free a run that is known to be reserved, now and then only part of it.
            idx = $urandom_range(0, live_runs.size() - 1);
            run = live_runs[idx];
            live_runs.delete(idx);
            offset = OFF_W'(run.base);
            length = LEN_W'(run.length);
            if ($urandom_range(0, 4) == 0) begin
               sub    = $urandom_range(0, run.length - 1);
               offset = OFF_W'(run.base + sub);
               length = LEN_W'($urandom_range(1, run.length - sub));
            end
         end else if (pick < 90) begin
            if ($urandom_range(0, 3) == 0) length = LEN_W'($urandom_range(1, LEN_MAX));
            else length = LEN_W'($urandom_range(1, 64));
         end else if (pick < 95) begin
            kind   = req_kind_type'($urandom_range(0, 1));
            length = '0;
         end else if (pick < 97) begin
            offset = '0;
            length = LEN_W'(HEAP_SIZE);
         end else begin
            // Free that ends exactly at, or one byte past, the top of the heap.
            sub    = $urandom_range(1, 64);
            offset = OFF_W'(HEAP_SIZE - sub);
            length = LEN_W'(sub + int'($urandom_range(0, 1)));
         end
         send_request(kind, offset, length, 1'b0, ST_OK, '0);
      end

      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
